// File: design/mfsh_pkg.sv
// Shared types and helpers for the max-frequency stack heap.
// No dependencies; used by the controller, datapath and top level.
package mfsh_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UP,
      ST_POP,
      ST_POP_RD,
      ST_DOWN,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SEARCH_NEXT,
      CMD_PUSH_HIT,
      CMD_PUSH_NEW,
      CMD_FAIL_FULL,
      CMD_FAIL_EMPTY,
      CMD_UP_STEP,
      CMD_POP_START,
      CMD_POP_TOP,
      CMD_DOWN_STEP,
      CMD_RESP_LOAD
   } cmd_type;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef struct packed {
      logic is_pop;
      logic search_end;
      logic hit;
      logic hit_full;
      logic heap_full;
      logic empty;
      logic pop_keeps;
      logic up_swap;
      logic down_swap;
      logic rsp_busy;
   } dp_status_type;

endpackage

// File: design/mfsh_ctrl.sv
// Sequencing controller for the max-frequency stack heap.
// Depends on mfsh_pkg; drives commands into mfsh_datapath.
module mfsh_ctrl
   import mfsh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type dp_status,
   output cmd_type       dp_cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (dp_status.is_pop) begin
               state_in = ST_POP;
            end else if (dp_status.hit) begin
               state_in = dp_status.hit_full ? ST_DONE : ST_UP;
            end else if (dp_status.search_end) begin
               state_in = dp_status.heap_full ? ST_DONE : ST_UP;
            end
         end
         ST_UP: begin
            if (!dp_status.up_swap) begin
               state_in = ST_DONE;
            end
         end
         ST_POP: begin
            priority if (dp_status.empty) begin
               state_in = ST_DONE;
            end else if (dp_status.pop_keeps) begin
               state_in = ST_POP_RD;
            end else begin
               state_in = ST_DOWN;
            end
         end
         ST_POP_RD: state_in = ST_DOWN;
         ST_DOWN: begin
            if (!dp_status.down_swap) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!dp_status.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd     = CMD_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               dp_cmd = CMD_LOAD;
            end
         end
         ST_SEARCH: begin
            if (!dp_status.is_pop) begin
               priority if (dp_status.hit) begin
                  dp_cmd = dp_status.hit_full ? CMD_FAIL_FULL : CMD_PUSH_HIT;
               end else if (dp_status.search_end) begin
                  dp_cmd = dp_status.heap_full ? CMD_FAIL_FULL : CMD_PUSH_NEW;
               end else begin
                  dp_cmd = CMD_SEARCH_NEXT;
               end
            end
         end
         ST_UP: begin
            if (dp_status.up_swap) begin
               dp_cmd = CMD_UP_STEP;
            end
         end
         ST_POP: dp_cmd = dp_status.empty ? CMD_FAIL_EMPTY : CMD_POP_START;
         ST_POP_RD: dp_cmd = CMD_POP_TOP;
         ST_DOWN: begin
            if (dp_status.down_swap) begin
               dp_cmd = CMD_DOWN_STEP;
            end
         end
         ST_DONE: begin
            if (!dp_status.rsp_busy) begin
               dp_cmd = CMD_RESP_LOAD;
            end
         end
         default: dp_cmd = CMD_NONE;
      endcase
   end

endmodule

// File: design/mfsh_datapath.sv
// Heap storage, stamp memory, compare logic and result register.
// Depends on mfsh_pkg; commanded by mfsh_ctrl.
module mfsh_datapath
   import mfsh_pkg::*;
#(
   parameter int HEAP_ENTRIES   = 16,
   parameter int STAMPS_PER_KEY = 16,
   parameter int KEY_BITS       = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       dp_cmd,
   output dp_status_type dp_status,
   input  logic          req_cmd,
   input  logic [15:0]   req_key,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [15:0]   rsp_popped,
   output logic [1:0]    rsp_status
);

   localparam int KW = (KEY_BITS < 16) ? KEY_BITS : 16;
   localparam int IW = $clog2(HEAP_ENTRIES);
   localparam int TW = $clog2(HEAP_ENTRIES + 1);
   localparam int CW = $clog2(STAMPS_PER_KEY + 1);
   localparam int AW = (HEAP_ENTRIES * STAMPS_PER_KEY > 1) ?
                       $clog2(HEAP_ENTRIES * STAMPS_PER_KEY) : 1;
   localparam int DW = IW + 2;

   logic [KW-1:0] key_ff  [HEAP_ENTRIES];
   logic [CW-1:0] cnt_ff  [HEAP_ENTRIES];
   logic [15:0]   top_ff  [HEAP_ENTRIES];
   logic [IW-1:0] slot_ff [HEAP_ENTRIES];
   logic [15:0]   stamp_mem [HEAP_ENTRIES * STAMPS_PER_KEY];

   logic [TW-1:0] total_ff;
   logic [15:0]   stamp_ff;
   logic [TW-1:0] idx_ff;
   logic [KW-1:0] in_key_ff;
   logic          is_pop_ff;
   logic [1:0]    status_ff;
   logic [15:0]   popped_ff;
   logic [15:0]   rd_data_ff;
   logic          rsp_valid_ff;
   logic [15:0]   rsp_popped_ff;
   logic [1:0]    rsp_status_ff;

   // ranking: higher count wins, equal counts go to the larger newest stamp
   function automatic logic above(input logic [CW-1:0] ca, input logic [15:0] ta,
                                  input logic [CW-1:0] cb, input logic [15:0] tb);
      if (ca != cb) begin
         return ca > cb;
      end
      return ta > tb;
   endfunction

   logic [IW-1:0] cur, parent, lidx, ridx, pick, last, swap_b;
   logic [DW-1:0] lw, rw;
   logic          l_in, r_in, lv, rv, pick_r;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [CW-1:0] dec_cnt;

   assign cur    = idx_ff[IW-1:0];
   assign parent = IW'((cur - IW'(1)) >> 1);
   assign lw     = DW'(idx_ff) * DW'(2) + DW'(1);
   assign rw     = lw + DW'(1);
   assign l_in   = lw < DW'(total_ff);
   assign r_in   = rw < DW'(total_ff);
   assign lidx   = lw[IW-1:0];
   assign ridx   = rw[IW-1:0];
   assign lv     = l_in && above(cnt_ff[lidx], top_ff[lidx], cnt_ff[cur], top_ff[cur]);
   assign rv     = r_in && above(cnt_ff[ridx], top_ff[ridx], cnt_ff[cur], top_ff[cur]);
   assign pick_r = rv && (!lv ||
                   !above(cnt_ff[lidx], top_ff[lidx], cnt_ff[ridx], top_ff[ridx]));
   assign pick   = pick_r ? ridx : lidx;
   assign last   = IW'(total_ff - TW'(1));
   assign dec_cnt = cnt_ff[0] - CW'(1);
   assign swap_b = (dp_cmd == CMD_UP_STEP) ? parent : pick;

   // a new entry starts its stack at the bottom; its count is stale until written
   assign wr_addr = AW'(slot_ff[cur]) * AW'(STAMPS_PER_KEY) +
                    ((dp_cmd == CMD_PUSH_NEW) ? AW'(0) : AW'(cnt_ff[cur]));
   assign rd_addr = AW'(slot_ff[0]) * AW'(STAMPS_PER_KEY) + AW'(cnt_ff[0]) - AW'(2);

   always_comb begin
      dp_status            = '0;
      dp_status.is_pop     = is_pop_ff;
      dp_status.search_end = idx_ff >= total_ff;
      dp_status.hit        = (idx_ff < total_ff) && (key_ff[cur] == in_key_ff);
      dp_status.hit_full   = cnt_ff[cur] == CW'(STAMPS_PER_KEY);
      dp_status.heap_full  = total_ff == TW'(HEAP_ENTRIES);
      dp_status.empty      = total_ff == '0;
      dp_status.pop_keeps  = cnt_ff[0] > CW'(1);
      dp_status.up_swap    = (idx_ff != '0) &&
                             above(cnt_ff[cur], top_ff[cur], cnt_ff[parent], top_ff[parent]);
      dp_status.down_swap  = lv || rv;
      dp_status.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (dp_cmd == CMD_PUSH_HIT || dp_cmd == CMD_PUSH_NEW) begin
         stamp_mem[wr_addr] <= stamp_ff;
      end
      rd_data_ff <= stamp_mem[rd_addr];
   end

   // heap arrays; slot ids stay a permutation so stamp stacks never move
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         stamp_ff <= '0;
         for (int k = 0; k < HEAP_ENTRIES; k++) begin
            slot_ff[k] <= IW'(k);
         end
      end else begin
         unique case (dp_cmd)
            CMD_PUSH_HIT: begin
               cnt_ff[cur] <= cnt_ff[cur] + CW'(1);
               top_ff[cur] <= stamp_ff;
               stamp_ff    <= stamp_ff + 16'd1;
            end
            CMD_PUSH_NEW: begin
               key_ff[cur] <= in_key_ff;
               cnt_ff[cur] <= CW'(1);
               top_ff[cur] <= stamp_ff;
               stamp_ff    <= stamp_ff + 16'd1;
               total_ff    <= total_ff + TW'(1);
            end
            CMD_UP_STEP, CMD_DOWN_STEP: begin
               key_ff[cur]     <= key_ff[swap_b];
               cnt_ff[cur]     <= cnt_ff[swap_b];
               top_ff[cur]     <= top_ff[swap_b];
               slot_ff[cur]    <= slot_ff[swap_b];
               key_ff[swap_b]  <= key_ff[cur];
               cnt_ff[swap_b]  <= cnt_ff[cur];
               top_ff[swap_b]  <= top_ff[cur];
               slot_ff[swap_b] <= slot_ff[cur];
            end
            CMD_POP_START: begin
               if (dec_cnt != '0) begin
                  cnt_ff[0] <= dec_cnt;
               end else begin
                  if (last != '0) begin
                     key_ff[0]     <= key_ff[last];
                     cnt_ff[0]     <= cnt_ff[last];
                     top_ff[0]     <= top_ff[last];
                     slot_ff[0]    <= slot_ff[last];
                     slot_ff[last] <= slot_ff[0];
                  end else begin
                     cnt_ff[0] <= '0;
                  end
                  total_ff <= total_ff - TW'(1);
               end
            end
            CMD_POP_TOP: top_ff[0] <= rd_data_ff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (dp_cmd)
         CMD_LOAD: begin
            in_key_ff <= req_key[KW-1:0];
            is_pop_ff <= req_cmd;
            idx_ff    <= '0;
            status_ff <= STATUS_OK;
            popped_ff <= '0;
         end
         CMD_SEARCH_NEXT: idx_ff <= idx_ff + TW'(1);
         CMD_FAIL_FULL:   status_ff <= STATUS_FULL;
         CMD_FAIL_EMPTY:  status_ff <= STATUS_EMPTY;
         CMD_UP_STEP:     idx_ff <= TW'(parent);
         CMD_DOWN_STEP:   idx_ff <= TW'(pick);
         CMD_POP_START:   popped_ff <= 16'(key_ff[0]);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd == CMD_RESP_LOAD) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd == CMD_RESP_LOAD) begin
         rsp_popped_ff <= popped_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_popped = rsp_popped_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// File: design/max_frequency_stack_heap.sv
// Top level of the max-frequency stack heap.
// Depends on mfsh_pkg, mfsh_ctrl and mfsh_datapath.
//
// Usage notes:
//  - Request channel: req_tuser[0] is the command (0 push, 1 pop), req_tdata
//    carries the key. One request is taken only while the block is idle.
//  - Response channel: one response per request. rsp_tdata[15:0] is the
//    popped key (zero on push or error), rsp_tdata[17:16] the status
//    (0 ok, 1 pop on empty heap, 2 push rejected as full).
//  - Operation: a push walks the stored keys one per cycle to find a match,
//    then sifts up one level per cycle. A pop updates the root in ST_POP,
//    plus ST_POP_RD to reload the top stamp when the key still has stamps,
//    then sifts down one level per cycle. The linear key search dominates.
//  - Stamp stacks never move: each heap slot points at a fixed stack in one
//    memory, so a swap only exchanges key, count, top stamp and pointer.
//  - Reset empties the heap and zeroes the push stamp.
//  - A finished response sits in an output register; the next request is
//    accepted while it waits, and a new result waits for the register.
module max_frequency_stack_heap
   import mfsh_pkg::*;
#(
   parameter int HEAP_ENTRIES   = 16,
   parameter int STAMPS_PER_KEY = 16,
   parameter int KEY_BITS       = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] key
   input  logic [0:0]  req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [15:0] popped_key, [17:16] status, rest zero
);

   dp_status_type dp_status;
   cmd_type       dp_cmd;
   logic [15:0]   rsp_popped;
   logic [1:0]    rsp_status;

   mfsh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   mfsh_datapath #(
      .HEAP_ENTRIES   (HEAP_ENTRIES),
      .STAMPS_PER_KEY (STAMPS_PER_KEY),
      .KEY_BITS       (KEY_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status),
      .req_cmd    (req_tuser[0]),
      .req_key    (req_tdata),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_popped (rsp_popped),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = {6'd0, rsp_status, rsp_popped};

endmodule

// File: design/mfsh_checker.sv
// Port-level checks for max_frequency_stack_heap, bound to the top level.
// Depends on mfsh_pkg for status codes.
module mfsh_checker
   import mfsh_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[17:16] != 2'd3 && rsp_tdata[23:18] == '0)
      else $error("bad status code or padding");

   a_err_key: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17:16] != STATUS_OK |-> rsp_tdata[15:0] == '0)
      else $error("error response carries a key");

   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid out of reset");

endmodule

bind max_frequency_stack_heap mfsh_checker u_mfsh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: sim/max_frequency_stack_heap_test.sv
// Self-checking bench for max_frequency_stack_heap: pushes and pops keys over
// the request stream, predicts each response in a local heap and compares.
// Depends on mfsh_pkg and the max_frequency_stack_heap top level.
module max_frequency_stack_heap_test;
   import mfsh_pkg::*;

   localparam int ENTRIES    = 16;
   localparam int STAMPS     = 16;
   localparam int STALL_LIMIT = 2000;  // idle cycles before the run is abandoned

   typedef struct packed {
      logic [15:0] key;
      logic [1:0]  status;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [15:0] key
   logic [0:0]  req_tuser = '0;   // [0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [15:0] popped_key, [17:16] status

   max_frequency_stack_heap u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Local heap: keys, counts and a stamp stack per slot, swapped whole.
   // ---------------------------------------------------------------------
   logic [15:0] heap_key   [ENTRIES];
   logic [4:0]  heap_count [ENTRIES];
   logic [15:0] heap_stamps[ENTRIES][STAMPS];
   int          live_entries = 0;
   logic [15:0] next_stamp   = '0;

   outcome_type pending_q[$];       // responses still owed by the block
   int          errors      = 0;
   int          n_push_ok   = 0;
   int          n_pop_ok    = 0;
   int          n_full      = 0;
   int          n_empty     = 0;
   bit          quiet       = 1'b0; // no idling on either side
   int unsigned cycle_no    = 0;
   int unsigned hold_end    = 0;    // receiver stalls until this cycle
   int unsigned idle_cycles = 0;

   function automatic logic [15:0] newest_stamp(int e);
      if (heap_count[e] == 0) return '0;
      return heap_stamps[e][heap_count[e] - 1];
   endfunction

   // a outranks b: more pushes, or equal pushes and the larger newest stamp
   function automatic bit outranks(int a, int b);
      if (heap_count[a] != heap_count[b]) return heap_count[a] > heap_count[b];
      return newest_stamp(a) > newest_stamp(b);
   endfunction

   function automatic void swap_slots(int a, int b);
      logic [15:0] k;
      logic [4:0]  c;
      logic [15:0] s;
      k = heap_key[a];   heap_key[a] = heap_key[b];     heap_key[b] = k;
      c = heap_count[a]; heap_count[a] = heap_count[b]; heap_count[b] = c;
      for (int j = 0; j < STAMPS; j++) begin
         s = heap_stamps[a][j];
         heap_stamps[a][j] = heap_stamps[b][j];
         heap_stamps[b][j] = s;
      end
   endfunction

   function automatic void raise_slot(int i);
      int p;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!outranks(i, p)) break;
         swap_slots(i, p);
         i = p;
      end
   endfunction

   function automatic void sink_root();
      int i, l, r, pick;
      bit lv, rv;
      i = 0;
      forever begin
         l = 2 * i + 1;
         r = l + 1;
         if (l >= live_entries) break;
         lv = outranks(l, i);
         rv = (r < live_entries) && outranks(r, i);
         if (!lv && !rv) break;
         if (lv && rv) pick = outranks(l, r) ? l : r;
         else          pick = lv ? l : r;
         swap_slots(i, pick);
         i = pick;
      end
   endfunction

   function automatic outcome_type heap_apply(logic cmd, logic [15:0] key);
      outcome_type res;
      int found, c, last;
      res = '{key: '0, status: STATUS_OK};
      found = -1;
      if (cmd == OP_PUSH) begin
         for (int i = 0; i < live_entries; i++)
            if (found < 0 && heap_key[i] == key) found = i;
         if (found >= 0) begin
            c = heap_count[found];
            if (c >= STAMPS) begin
               res.status = STATUS_FULL;
            end else begin
               heap_stamps[found][c] = next_stamp;
               heap_count[found] = 5'(c + 1);
               next_stamp++;
               raise_slot(found);
            end
         end else if (live_entries >= ENTRIES) begin
            res.status = STATUS_FULL;
         end else begin
            heap_key[live_entries] = key;
            heap_count[live_entries] = 5'd1;
            heap_stamps[live_entries][0] = next_stamp;
            next_stamp++;
            live_entries++;
            raise_slot(live_entries - 1);
         end
      end else if (live_entries == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         res.key = heap_key[0];
         heap_count[0]--;
         if (heap_count[0] == 0) begin
            last = live_entries - 1;
            if (last != 0) begin
               heap_key[0] = heap_key[last];
               heap_count[0] = heap_count[last];
               for (int j = 0; j < STAMPS; j++) heap_stamps[0][j] = heap_stamps[last][j];
            end
            live_entries = last;
         end
         sink_root();
      end
      case (res.status)
         STATUS_FULL:  n_full++;
         STATUS_EMPTY: n_empty++;
         default:      if (cmd == OP_PUSH) n_push_ok++; else n_pop_ok++;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Request side: one request per call, valid held high across back-to-back
   // calls; random gaps unless quiet.
   // ---------------------------------------------------------------------
   task automatic send_request(logic cmd, logic [15:0] key);
      if (!quiet && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tuser[0] <= cmd;
      req_tdata    <= key;
      do @(posedge clock); while (!req_tready);
      pending_q.insert(pending_q.size(), heap_apply(cmd, key));
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   task automatic pop_all();
      while (live_entries != 0) send_request(OP_POP, 16'($urandom));
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stalls plus long hold-offs on request.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (cycle_no < hold_end) rsp_tready <= 1'b0;
      else                     rsp_tready <= quiet || ($urandom_range(99) >= 9);
   end

   always @(posedge clock) begin
      outcome_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_tdata);
            errors++;
         end else begin
            exp_r = pending_q.pop_front();
            if (rsp_tdata[15:0] !== exp_r.key) begin
               $display("%0t: popped_key expected %h actual %h",
                        $time, exp_r.key, rsp_tdata[15:0]);
               errors++;
            end
            if (rsp_tdata[17:16] !== exp_r.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, exp_r.status, rsp_tdata[17:16]);
               errors++;
            end
         end
      end
   end

   // Watchdog: cycles with neither handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_empty_pop();
      send_request(OP_POP, 16'hFFFF);
      send_request(OP_POP, 16'h0000);
   endtask

   // extreme keys, frequency order and newest-wins ties
   task automatic test_key_order();
      send_request(OP_PUSH, 16'h0000);
      send_request(OP_PUSH, 16'hFFFF);
      send_request(OP_PUSH, 16'h5555);
      send_request(OP_PUSH, 16'hAAAA);
      send_request(OP_PUSH, 16'h0000);
      send_request(OP_PUSH, 16'hFFFF);
      repeat (7) send_request(OP_POP, 16'h1234);
   endtask

   // random run over a key pool; push_pct biases towards filling up
   task automatic test_random_mix(int items, int pool, int push_pct);
      logic [15:0] keys[32];
      foreach (keys[i]) keys[i] = 16'($urandom);
      repeat (items) begin
         if ($urandom_range(99) < push_pct)
            send_request(OP_PUSH, ($urandom_range(9) == 0) ? 16'($urandom)
                                                           : keys[$urandom_range(pool - 1)]);
         else
            send_request(OP_POP, 16'($urandom));
      end
   endtask

   // receiver holds off while requests keep coming, then sender waits
   task automatic test_backpressure();
      hold_end = cycle_no + 400;
      repeat (12) send_request(1'($urandom_range(1)), 16'($urandom_range(3)));
      settle();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_pop();
      test_key_order();
      settle();
      test_random_mix(220, 32, 85);   // fills the heap, hits heap full
      pop_all();
      test_random_mix(160, 3, 90);    // deep stamp stacks, hits stack full
      test_backpressure();
      quiet = 1'b1;
      test_random_mix(100, 8, 60);    // stretch without idling
      quiet = 1'b0;
      test_random_mix(100, 32, 50);
      settle();
      test_random_mix(40, 4, 55);

      settle();
      repeat (40) @(posedge clock);
      $display("Covered %0d good pushes, %0d good pops, %0d full rejects, %0d empty pops,",
               n_push_ok, n_pop_ok, n_full, n_empty);
      $display("a long receiver hold-off and a stretch without idling; %0d mismatches.",
               errors);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
